@@ src/odq_pkg.sv @@
package odq_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int ID_W     = 32;
    localparam int HANDLE_W = 16;
    localparam int POS_W    = 8;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        REQ_INS_POS   = 3'd0,
        REQ_INS_FRONT = 3'd1,
        REQ_INS_BACK  = 3'd2,
        REQ_RM_FRONT  = 3'd3,
        REQ_RM_BACK   = 3'd4,
        REQ_FIND      = 3'd5,
        REQ_RD_FRONT  = 3'd6,
        REQ_RD_BACK   = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic from_left;
        logic from_right;
    } t_cell_ctl;

endpackage

@@ src/odq_cell.sv @@
module odq_cell (
    input  logic                          i_clk,
    input  odq_pkg::t_cell_ctl            i_ctl,
    input  logic [odq_pkg::ID_W-1:0]      i_new_id,
    input  logic [odq_pkg::HANDLE_W-1:0]  i_new_handle,
    input  logic [odq_pkg::ID_W-1:0]      i_left_id,
    input  logic [odq_pkg::HANDLE_W-1:0]  i_left_handle,
    input  logic [odq_pkg::ID_W-1:0]      i_right_id,
    input  logic [odq_pkg::HANDLE_W-1:0]  i_right_handle,
    input  logic [odq_pkg::ID_W-1:0]      i_search_id,
    output logic [odq_pkg::ID_W-1:0]      o_id,
    output logic [odq_pkg::HANDLE_W-1:0]  o_handle,
    output logic                          o_match
);

    logic [odq_pkg::ID_W-1:0]     r_id;
    logic [odq_pkg::HANDLE_W-1:0] r_handle;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_id     <= i_new_id;
            r_handle <= i_new_handle;
        end else if (i_ctl.from_left) begin
            r_id     <= i_left_id;
            r_handle <= i_left_handle;
        end else if (i_ctl.from_right) begin
            r_id     <= i_right_id;
            r_handle <= i_right_handle;
        end
    end

    assign o_id     = r_id;
    assign o_handle = r_handle;
    assign o_match  = (r_id == i_search_id);

endmodule

@@ src/ordered_deque_with_search_core.sv @@
// ordered list of up to odq_pkg::DEPTH entries (id, handle), front at cell 0
// requests: pulse start with the fields while busy is low; the transfer happens at
// that edge and the fields are captured, so they need not be held afterwards
// busy is high in the cycle after a transfer, in which the request is executed
// against the row of cells: inserts shift the cells behind the insert point one
// place back, a front removal shifts them one place forward, a find compares every
// cell at once and picks the frontmost hit
// o_valid rises in the cycle after the execute cycle and stays high for one cycle
// no new request is taken while busy, that is during the execute cycle in which the
// cells shift and the first-hit select runs
// every request gives exactly one result: status, the entry read, removed or found
// (zero otherwise) and the occupancy after the request
// the receiver cannot stall; each result is valid for its strobe cycle only
// reset (synchronous, active low) empties the list and drops any request in flight;
// cell contents are not cleared, only cells below the occupancy are ever read
module ordered_deque_with_search_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_req_type,
    input  logic [odq_pkg::POS_W-1:0]     i_position,
    input  logic [odq_pkg::ID_W-1:0]      i_entry_id,
    input  logic [odq_pkg::HANDLE_W-1:0]  i_entry_handle,
    input  logic [odq_pkg::ID_W-1:0]      i_search_id,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [odq_pkg::ID_W-1:0]      o_out_id,
    output logic [odq_pkg::HANDLE_W-1:0]  o_out_handle,
    output logic [odq_pkg::CNT_W-1:0]     o_occupancy
);

    localparam int D = odq_pkg::DEPTH;

    logic                          r_exec;
    logic                          r_valid;
    logic [odq_pkg::CNT_W-1:0]     r_count;
    logic [odq_pkg::CNT_W-1:0]     n_count;
    odq_pkg::t_req                 r_req;
    logic [odq_pkg::POS_W-1:0]     r_pos;
    logic [odq_pkg::ID_W-1:0]      r_new_id;
    logic [odq_pkg::HANDLE_W-1:0]  r_new_handle;
    logic [odq_pkg::ID_W-1:0]      r_search_id;

    odq_pkg::t_status              r_status;
    odq_pkg::t_status              n_status;
    logic [odq_pkg::ID_W-1:0]      r_out_id;
    logic [odq_pkg::ID_W-1:0]      n_out_id;
    logic [odq_pkg::HANDLE_W-1:0]  r_out_handle;
    logic [odq_pkg::HANDLE_W-1:0]  n_out_handle;

    logic [odq_pkg::ID_W-1:0]      w_id     [D];
    logic [odq_pkg::HANDLE_W-1:0]  w_handle [D];
    logic [D-1:0]                  w_match;
    logic [D-1:0]                  w_hit;
    logic [D-1:0]                  w_first;
    logic [D-1:0]                  w_sel_back;
    logic [D-1:0]                  w_sel;
    odq_pkg::t_cell_ctl            w_ctl [D];

    logic                          w_full;
    logic                          w_empty;
    logic                          w_do_ins;
    logic                          w_do_rmf;
    logic [odq_pkg::CNT_W-1:0]     w_ins_idx;
    logic [odq_pkg::CMP_W-1:0]     w_pos_ext;
    logic [odq_pkg::CMP_W-1:0]     w_cnt_ext;
    logic [odq_pkg::CMP_W-1:0]     w_pos_m1;

    assign busy = r_exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec  <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_exec  <= start && !r_exec;
            r_valid <= r_exec;
            if (r_exec) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_exec) begin
            r_req        <= odq_pkg::t_req'(i_req_type);
            r_pos        <= i_position;
            r_new_id     <= i_entry_id;
            r_new_handle <= i_entry_handle;
            r_search_id  <= i_search_id;
        end
        if (r_exec) begin
            r_status     <= n_status;
            r_out_id     <= n_out_id;
            r_out_handle <= n_out_handle;
        end
    end

    assign w_full    = (r_count == odq_pkg::CNT_W'(D));
    assign w_empty   = (r_count == '0);
    assign w_pos_ext = odq_pkg::CMP_W'(r_pos);
    assign w_cnt_ext = odq_pkg::CMP_W'(r_count);
    assign w_pos_m1  = w_pos_ext - odq_pkg::CMP_W'(1);

    // insert point: front, back, or position minus one
    always_comb begin
        if (r_req == odq_pkg::REQ_INS_FRONT || w_empty || r_pos <= odq_pkg::POS_W'(1)) begin
            w_ins_idx = '0;
        end else if (r_req == odq_pkg::REQ_INS_BACK || w_pos_ext > w_cnt_ext) begin
            w_ins_idx = r_count;
        end else begin
            w_ins_idx = w_pos_m1[odq_pkg::CNT_W-1:0];
        end
    end

    // frontmost hit among occupied cells
    assign w_first = w_hit & (~w_hit + D'(1));

    always_comb begin
        n_count  = r_count;
        n_status = odq_pkg::ST_OK;
        w_do_ins = 1'b0;
        w_do_rmf = 1'b0;
        w_sel    = '0;
        unique case (r_req) inside
            odq_pkg::REQ_INS_POS, odq_pkg::REQ_INS_FRONT, odq_pkg::REQ_INS_BACK: begin
                if (w_full) begin
                    n_status = odq_pkg::ST_FULL;
                end else begin
                    w_do_ins = r_exec;
                    n_count  = r_count + odq_pkg::CNT_W'(1);
                end
            end
            odq_pkg::REQ_RM_FRONT, odq_pkg::REQ_RM_BACK,
            odq_pkg::REQ_RD_FRONT, odq_pkg::REQ_RD_BACK: begin
                if (w_empty) begin
                    n_status = odq_pkg::ST_EMPTY;
                end else begin
                    if (r_req == odq_pkg::REQ_RM_FRONT || r_req == odq_pkg::REQ_RD_FRONT) begin
                        w_sel = D'(1);
                    end else begin
                        w_sel = w_sel_back;
                    end
                    if (r_req == odq_pkg::REQ_RM_FRONT || r_req == odq_pkg::REQ_RM_BACK) begin
                        n_count = r_count - odq_pkg::CNT_W'(1);
                    end
                    w_do_rmf = r_exec && (r_req == odq_pkg::REQ_RM_FRONT);
                end
            end
            odq_pkg::REQ_FIND: begin
                if (w_first == '0) begin
                    n_status = odq_pkg::ST_EMPTY;
                end else begin
                    w_sel = w_first;
                end
            end
        endcase
    end

    always_comb begin
        n_out_id     = '0;
        n_out_handle = '0;
        for (int k = 0; k < D; k++) begin
            n_out_id     = n_out_id     | (w_id[k]     & {odq_pkg::ID_W{w_sel[k]}});
            n_out_handle = n_out_handle | (w_handle[k] & {odq_pkg::HANDLE_W{w_sel[k]}});
        end
    end

    for (genvar i = 0; i < D; i++) begin : g_cell
        localparam logic [odq_pkg::CNT_W-1:0] CI  = odq_pkg::CNT_W'(i);
        localparam logic [odq_pkg::CNT_W-1:0] CI1 = odq_pkg::CNT_W'(i + 1);

        logic [odq_pkg::ID_W-1:0]     w_l_id;
        logic [odq_pkg::HANDLE_W-1:0] w_l_handle;
        logic [odq_pkg::ID_W-1:0]     w_r_id;
        logic [odq_pkg::HANDLE_W-1:0] w_r_handle;

        if (i == 0) begin : g_first
            assign w_l_id     = w_id[0];
            assign w_l_handle = w_handle[0];
        end else begin : g_mid_l
            assign w_l_id     = w_id[i-1];
            assign w_l_handle = w_handle[i-1];
        end
        if (i == D - 1) begin : g_last
            assign w_r_id     = w_id[D-1];
            assign w_r_handle = w_handle[D-1];
        end else begin : g_mid_r
            assign w_r_id     = w_id[i+1];
            assign w_r_handle = w_handle[i+1];
        end

        assign w_ctl[i].load       = w_do_ins && (CI == w_ins_idx);
        assign w_ctl[i].from_left  = w_do_ins && (CI > w_ins_idx) && (CI <= r_count);
        assign w_ctl[i].from_right = w_do_rmf && (CI1 < r_count);

        assign w_hit[i]      = w_match[i] && (CI < r_count);
        assign w_sel_back[i] = (CI1 == r_count);

        odq_cell u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl[i]),
            .i_new_id       (r_new_id),
            .i_new_handle   (r_new_handle),
            .i_left_id      (w_l_id),
            .i_left_handle  (w_l_handle),
            .i_right_id     (w_r_id),
            .i_right_handle (w_r_handle),
            .i_search_id    (r_search_id),
            .o_id           (w_id[i]),
            .o_handle       (w_handle[i]),
            .o_match        (w_match[i])
        );
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_out_id     = r_out_id;
    assign o_out_handle = r_out_handle;
    assign o_occupancy  = r_count;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_occupancy <= odq_pkg::CNT_W'(D)))
        else $error("occupancy beyond depth");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == odq_pkg::ST_FULL) |-> (o_occupancy == odq_pkg::CNT_W'(D)))
        else $error("full status with room left");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted request gave no result");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && $past(r_exec) && $past(i_rst_n)) |->
            (r_count == $past(r_count) || r_count == $past(r_count) + odq_pkg::CNT_W'(1)
             || r_count == $past(r_count) - odq_pkg::CNT_W'(1)))
        else $error("occupancy moved by more than one");

endmodule

@@ bench/ordered_deque_with_search_core_test.sv @@
`timescale 1ns / 1ps

module ordered_deque_with_search_core_test;

    localparam int RANDOM_ITEMS = 1830;
    localparam int CALM_TAIL    = 250;
    localparam int STALL_LIMIT  = 500;

    typedef struct packed {
        odq_pkg::t_req                req;
        logic [odq_pkg::POS_W-1:0]    pos;
        logic [odq_pkg::ID_W-1:0]     id;
        logic [odq_pkg::HANDLE_W-1:0] hdl;
        logic [odq_pkg::ID_W-1:0]     sid;
    } t_request;

    typedef struct packed {
        odq_pkg::t_status             st;
        logic [odq_pkg::ID_W-1:0]     id;
        logic [odq_pkg::HANDLE_W-1:0] hdl;
        logic [odq_pkg::CNT_W-1:0]    occ;
    } t_outcome;

    typedef struct packed {
        t_request rq;
        logic     typed;
        t_outcome want;
    } t_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [2:0]                   i_req_type;
    logic [odq_pkg::POS_W-1:0]    i_position;
    logic [odq_pkg::ID_W-1:0]     i_entry_id;
    logic [odq_pkg::HANDLE_W-1:0] i_entry_handle;
    logic [odq_pkg::ID_W-1:0]     i_search_id;
    logic                         o_valid;
    logic [1:0]                   o_status;
    logic [odq_pkg::ID_W-1:0]     o_out_id;
    logic [odq_pkg::HANDLE_W-1:0] o_out_handle;
    logic [odq_pkg::CNT_W-1:0]    o_occupancy;

    // request on the ports, with its typed expectation where there is one
    t_request drv_rq;
    logic     drv_typed;
    t_outcome drv_want;

    // shadow copy of the list, front at index 0
    logic [odq_pkg::ID_W-1:0]     held_ids [odq_pkg::DEPTH];
    logic [odq_pkg::HANDLE_W-1:0] held_handles [odq_pkg::DEPTH];
    int                           list_len;

    t_outcome outcomes_due [$];
    t_row     script [$];
    int       mismatches;
    int       stall_cycles;

    ordered_deque_with_search_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_outcome apply_request(t_request rq);
        t_outcome o;
        int       at;
        int       k;
        o = '0;
        o.st = odq_pkg::ST_OK;
        case (rq.req)
            odq_pkg::REQ_INS_POS, odq_pkg::REQ_INS_FRONT, odq_pkg::REQ_INS_BACK: begin
                if (list_len >= odq_pkg::DEPTH) begin
                    o.st = odq_pkg::ST_FULL;
                end else begin
                    if (rq.req == odq_pkg::REQ_INS_FRONT || list_len == 0 || rq.pos <= 1) begin
                        at = 0;
                    end else if (rq.req == odq_pkg::REQ_INS_BACK || rq.pos > list_len) begin
                        at = list_len;
                    end else begin
                        at = rq.pos - 1;
                    end
                    for (k = list_len; k > at; k--) begin
                        held_ids[k]     = held_ids[k-1];
                        held_handles[k] = held_handles[k-1];
                    end
                    held_ids[at]     = rq.id;
                    held_handles[at] = rq.hdl;
                    list_len++;
                end
            end
            odq_pkg::REQ_FIND: begin
                o.st = odq_pkg::ST_EMPTY;
                // frontmost hit wins
                for (k = 0; k < list_len && o.st != odq_pkg::ST_OK; k++) begin
                    if (held_ids[k] == rq.sid) begin
                        o.st  = odq_pkg::ST_OK;
                        o.id  = held_ids[k];
                        o.hdl = held_handles[k];
                    end
                end
            end
            default: begin
                if (list_len == 0) begin
                    o.st = odq_pkg::ST_EMPTY;
                end else begin
                    at = (rq.req == odq_pkg::REQ_RM_FRONT || rq.req == odq_pkg::REQ_RD_FRONT)
                         ? 0 : list_len - 1;
                    o.id  = held_ids[at];
                    o.hdl = held_handles[at];
                    if (rq.req == odq_pkg::REQ_RM_FRONT || rq.req == odq_pkg::REQ_RM_BACK) begin
                        for (k = at; k + 1 < list_len; k++) begin
                            held_ids[k]     = held_ids[k+1];
                            held_handles[k] = held_handles[k+1];
                        end
                        list_len--;
                    end
                end
            end
        endcase
        o.occ = list_len[odq_pkg::CNT_W-1:0];
        return o;
    endfunction

    task automatic check_field(string name, logic [odq_pkg::ID_W-1:0] want,
                               logic [odq_pkg::ID_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (o_valid) begin
                stall_cycles = 0;
                if (outcomes_due.size() == 0) begin
                    $error("result with nothing outstanding: status %0d id 'h%0h",
                           o_status, o_out_id);
                    mismatches++;
                end else begin
                    want = outcomes_due.pop_front();
                    check_field("status", odq_pkg::ID_W'(want.st),
                                odq_pkg::ID_W'(o_status));
                    check_field("out_id", want.id, o_out_id);
                    check_field("out_handle", odq_pkg::ID_W'(want.hdl),
                                odq_pkg::ID_W'(o_out_handle));
                    check_field("occupancy", odq_pkg::ID_W'(want.occ),
                                odq_pkg::ID_W'(o_occupancy));
                end
            end
            if (start && !busy) begin
                stall_cycles = 0;
                want = apply_request(drv_rq);
                outcomes_due.push_back(drv_typed ? drv_want : want);
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic add_row(odq_pkg::t_req req, logic [odq_pkg::POS_W-1:0] pos,
                           logic [odq_pkg::ID_W-1:0] id,
                           logic [odq_pkg::HANDLE_W-1:0] hdl,
                           logic [odq_pkg::ID_W-1:0] sid, logic typed,
                           odq_pkg::t_status st, logic [odq_pkg::ID_W-1:0] oid,
                           logic [odq_pkg::HANDLE_W-1:0] oh, int occ);
        t_row r;
        r.rq       = '{req: req, pos: pos, id: id, hdl: hdl, sid: sid};
        r.typed    = typed;
        r.want     = '{st: st, id: oid, hdl: oh, occ: occ[odq_pkg::CNT_W-1:0]};
        script.push_back(r);
    endtask

    task automatic send(t_request rq, logic typed, t_outcome want);
        @(negedge i_clk);
        start          <= 1'b1;
        i_req_type     <= rq.req;
        i_position     <= rq.pos;
        i_entry_id     <= rq.id;
        i_entry_handle <= rq.hdl;
        i_search_id    <= rq.sid;
        drv_rq         <= rq;
        drv_typed      <= typed;
        drv_want       <= want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // start low, fields wandering
    task automatic pause(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start          <= 1'b0;
            i_req_type     <= 3'($urandom);
            i_position     <= odq_pkg::POS_W'($urandom);
            i_entry_id     <= odq_pkg::ID_W'($urandom);
            i_entry_handle <= odq_pkg::HANDLE_W'($urandom);
            i_search_id    <= odq_pkg::ID_W'($urandom);
        end
    endtask

    initial begin : stimulus
        t_request                 rq;
        logic [odq_pkg::ID_W-1:0] id_pool [8];
        bit                       filling;
        bit                       gappy;
        int                       n;
        int                       r;

        start          = 1'b0;
        i_rst_n        = 1'b0;
        i_req_type     = '0;
        i_position     = '0;
        i_entry_id     = '0;
        i_entry_handle = '0;
        i_search_id    = '0;
        drv_rq         = '0;
        drv_typed      = 1'b0;
        drv_want       = '0;
        list_len       = 0;
        mismatches     = 0;
        stall_cycles   = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list first, then fill from both ends and the middle
        add_row(odq_pkg::REQ_RM_FRONT, 8'd0, 32'h0, 16'h0, 32'h0,
                1'b1, odq_pkg::ST_EMPTY, 32'h0, 16'h0, 0);
        add_row(odq_pkg::REQ_RM_BACK, 8'd0, 32'h0, 16'h0, 32'h0,
                1'b1, odq_pkg::ST_EMPTY, 32'h0, 16'h0, 0);
        add_row(odq_pkg::REQ_RD_FRONT, 8'd0, 32'h0, 16'h0, 32'h0,
                1'b1, odq_pkg::ST_EMPTY, 32'h0, 16'h0, 0);
        add_row(odq_pkg::REQ_RD_BACK, 8'd0, 32'h0, 16'h0, 32'h0,
                1'b1, odq_pkg::ST_EMPTY, 32'h0, 16'h0, 0);
        add_row(odq_pkg::REQ_FIND, 8'd0, 32'h0, 16'h0, 32'h0,
                1'b1, odq_pkg::ST_EMPTY, 32'h0, 16'h0, 0);
        add_row(odq_pkg::REQ_INS_POS, 8'd200, 32'hFFFF_FFFF, 16'hFFFF, 32'h0,
                1'b1, odq_pkg::ST_OK, 32'h0, 16'h0, 1);
        add_row(odq_pkg::REQ_INS_POS, 8'd0, 32'h0, 16'h0, 32'hFFFF_FFFF,
                1'b1, odq_pkg::ST_OK, 32'h0, 16'h0, 2);
        add_row(odq_pkg::REQ_INS_POS, 8'd1, 32'h1, 16'h1, 32'h0,
                1'b1, odq_pkg::ST_OK, 32'h0, 16'h0, 3);
        add_row(odq_pkg::REQ_INS_POS, 8'd2, 32'h22, 16'h22, 32'h0,
                1'b1, odq_pkg::ST_OK, 32'h0, 16'h0, 4);
        add_row(odq_pkg::REQ_INS_POS, 8'd255, 32'h33, 16'h33, 32'h0,
                1'b1, odq_pkg::ST_OK, 32'h0, 16'h0, 5);
        add_row(odq_pkg::REQ_INS_POS, 8'd5, 32'h44, 16'h44, 32'h0,
                1'b1, odq_pkg::ST_OK, 32'h0, 16'h0, 6);
        add_row(odq_pkg::REQ_INS_POS, 8'd7, 32'h55, 16'h55, 32'h0,
                1'b1, odq_pkg::ST_OK, 32'h0, 16'h0, 7);
        add_row(odq_pkg::REQ_INS_FRONT, 8'd9, 32'h8000_0000, 16'h8000, 32'h0,
                1'b1, odq_pkg::ST_OK, 32'h0, 16'h0, 8);
        add_row(odq_pkg::REQ_INS_BACK, 8'd1, 32'h7FFF_FFFF, 16'h7FFF, 32'h0,
                1'b1, odq_pkg::ST_OK, 32'h0, 16'h0, 9);
        add_row(odq_pkg::REQ_INS_BACK, 8'd0, 32'h1, 16'h1234, 32'h0,
                1'b1, odq_pkg::ST_OK, 32'h0, 16'h0, 10);
        add_row(odq_pkg::REQ_FIND, 8'd0, 32'h0, 16'h0, 32'hDEAD_BEEF,
                1'b1, odq_pkg::ST_EMPTY, 32'h0, 16'h0, 10);
        add_row(odq_pkg::REQ_FIND, 8'd0, 32'h0, 16'h0, 32'hFFFF_FFFF,
                1'b0, odq_pkg::ST_OK, 32'h0, 16'h0, 0);
        add_row(odq_pkg::REQ_FIND, 8'd0, 32'h0, 16'h0, 32'h0,
                1'b0, odq_pkg::ST_OK, 32'h0, 16'h0, 0);
        add_row(odq_pkg::REQ_FIND, 8'd0, 32'h0, 16'h0, 32'h1,
                1'b0, odq_pkg::ST_OK, 32'h0, 16'h0, 0);
        add_row(odq_pkg::REQ_RD_FRONT, 8'd0, 32'h0, 16'h0, 32'h0,
                1'b0, odq_pkg::ST_OK, 32'h0, 16'h0, 0);
        add_row(odq_pkg::REQ_RD_BACK, 8'd0, 32'h0, 16'h0, 32'h0,
                1'b0, odq_pkg::ST_OK, 32'h0, 16'h0, 0);
        add_row(odq_pkg::REQ_RM_FRONT, 8'd0, 32'h0, 16'h0, 32'h0,
                1'b0, odq_pkg::ST_OK, 32'h0, 16'h0, 0);
        add_row(odq_pkg::REQ_RM_BACK, 8'd0, 32'h0, 16'h0, 32'h0,
                1'b0, odq_pkg::ST_OK, 32'h0, 16'h0, 0);

        foreach (script[i]) begin
            if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 7));
            send(script[i].rq, script[i].typed, script[i].want);
        end

        // small id pool so that finds hit and duplicates occur
        id_pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h5A5A_A5A5, 32'h0000_FFFF, 32'hFFFF_0000};
        filling = 1'b1;
        gappy   = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) gappy = ($urandom_range(0, 2) != 0);
            // sweep between full and empty so both ends are hit often
            if (list_len == odq_pkg::DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
            if (list_len == 0 && $urandom_range(0, 1) == 0) filling = 1'b1;
            if ($urandom_range(0, 99) < 3) filling = !filling;

            r = $urandom_range(0, 99);
            if (filling) begin
                rq.req = (r < 70) ? odq_pkg::t_req'($urandom_range(0, 2))
                                  : odq_pkg::t_req'($urandom_range(3, 7));
            end else begin
                rq.req = (r < 65) ? odq_pkg::t_req'($urandom_range(3, 4))
                                  : odq_pkg::t_req'($urandom_range(0, 7));
            end
            rq.pos = ($urandom_range(0, 9) < 7)
                     ? odq_pkg::POS_W'($urandom_range(0, list_len + 2))
                     : odq_pkg::POS_W'($urandom_range(0, 255));
            rq.id  = ($urandom_range(0, 1) == 0) ? id_pool[$urandom_range(0, 7)]
                                                 : odq_pkg::ID_W'($urandom);
            rq.hdl = odq_pkg::HANDLE_W'($urandom_range(0, 65535));
            r = $urandom_range(0, 9);
            if (r < 6 && list_len > 0) begin
                rq.sid = held_ids[$urandom_range(0, list_len - 1)];
            end else if (r < 8) begin
                rq.sid = id_pool[$urandom_range(0, 7)];
            end else begin
                rq.sid = odq_pkg::ID_W'($urandom);
            end

            if (n < RANDOM_ITEMS - CALM_TAIL && gappy && $urandom_range(0, 3) == 0) begin
                pause($urandom_range(1, 7));
            end
            send(rq, 1'b0, '0);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
